/* rtl/ovl_pkg.sv */
`default_nettype none

package ovl_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OUT_W    = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    // Reduce a count or index to the 5-bit result width.
    function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] x);
        logic [CNT_W+OUT_W-1:0] t;
        t = {{OUT_W{1'b0}}, x};
        return t[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/ovl_mem.sv */
`default_nettype none

module ovl_mem (
    input  wire logic                       aclk,
    input  wire ovl_pkg::mem_req_t          req,
    output logic [ovl_pkg::DATA_W-1:0]      rd_data
);

    logic [ovl_pkg::DATA_W-1:0] mem [ovl_pkg::CAPACITY];

    // Write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[req.raddr];
    end

endmodule

`default_nettype wire

/* rtl/ordered_value_list.sv */
`default_nettype none

// Channel  | Direction | Ports                                          | Handshake
// ---------+-----------+------------------------------------------------+-----------
// s_       | in        | s_kind, s_value                                | s_valid/s_ready
// m_       | out       | m_found, m_position, m_entry_count, m_overflow | m_valid/m_ready
//
// Append and clear go from the accepting step straight to the result load.
// Search compares entries from the head until a match or the end (0 to count entries);
// the single comparator walks the store one entry per cycle through its read port.
// Remove then moves each later entry up one place (one read, one write a cycle).
// Reset (aresetn, synchronous, active low) empties the list; the store is not cleared.
// A finished result waits in the output register while the next beat is accepted;
// the sequencer only stalls in its last step until that register is free.

module ordered_value_list (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_kind,
    input  wire logic signed [31:0]            s_value,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_found,
    output logic [4:0]                         m_position,
    output logic [4:0]                         m_entry_count,
    output logic                               m_overflow
);

    localparam int CW = ovl_pkg::CNT_W;
    localparam int IW = ovl_pkg::IDX_W;

    ovl_pkg::state_t            state_reg, state_next;
    ovl_pkg::kind_t             kind_reg, kind_next;
    logic [31:0]                value_reg, value_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       found_reg, found_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic                       ovf_reg, ovf_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_found_reg, m_found_next;
    logic [4:0]                 m_pos_reg, m_pos_next;
    logic [4:0]                 m_cnt_reg, m_cnt_next;
    logic                       m_ovf_reg, m_ovf_next;

    ovl_pkg::mem_req_t          mem_req;
    logic [31:0]                rd_data;

    logic [CW:0]                idx_inc;
    logic [CW:0]                idx_two;
    logic [CW:0]                count_ext;

    ovl_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign idx_inc   = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_two   = {1'b0, idx_reg} + (CW+1)'(2);
    assign count_ext = {1'b0, count_reg};

    assign s_ready       = (state_reg == ovl_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_position    = m_pos_reg;
    assign m_entry_count = m_cnt_reg;
    assign m_overflow    = m_ovf_reg;

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        ovf_next     = ovf_reg;

        m_valid_next = m_valid_reg & ~m_ready;
        m_found_next = m_found_reg;
        m_pos_next   = m_pos_reg;
        m_cnt_next   = m_cnt_reg;
        m_ovf_next   = m_ovf_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[IW-1:0];
        mem_req.wdata = s_value;
        mem_req.raddr = '0;

        case (state_reg)
            ovl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = ovl_pkg::kind_t'(s_kind);
                    value_next = s_value;
                    found_next = 1'b0;
                    pos_next   = '0;
                    ovf_next   = 1'b0;
                    idx_next   = '0;
                    case (ovl_pkg::kind_t'(s_kind))
                        ovl_pkg::KIND_APPEND: begin
                            // Drop the value when the list is full
                            if (count_reg >= CW'(ovl_pkg::CAPACITY)) begin
                                ovf_next = 1'b1;
                            end else begin
                                mem_req.we = 1'b1;
                                pos_next   = count_reg;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = ovl_pkg::ST_FIN;
                        end
                        ovl_pkg::KIND_SEARCH, ovl_pkg::KIND_REMOVE: begin
                            // Issue the read of the head entry
                            if (count_reg == '0) begin
                                state_next = ovl_pkg::ST_FIN;
                            end else begin
                                state_next = ovl_pkg::ST_SCAN;
                            end
                        end
                        ovl_pkg::KIND_CLEAR: begin
                            count_next = '0;
                            state_next = ovl_pkg::ST_FIN;
                        end
                        default: begin
                            state_next = ovl_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            ovl_pkg::ST_SCAN: begin
                // rd_data holds the entry at idx_reg
                if (rd_data == value_reg) begin
                    found_next = 1'b1;
                    pos_next   = idx_reg;
                    if (kind_reg == ovl_pkg::KIND_REMOVE) begin
                        if (idx_inc < count_ext) begin
                            // Start closing the gap: fetch the next entry
                            mem_req.raddr = idx_inc[IW-1:0];
                            state_next    = ovl_pkg::ST_SHIFT;
                        end else begin
                            count_next = count_reg - CW'(1);
                            state_next = ovl_pkg::ST_FIN;
                        end
                    end else begin
                        state_next = ovl_pkg::ST_FIN;
                    end
                end else if (idx_inc >= count_ext) begin
                    state_next = ovl_pkg::ST_FIN;
                end else begin
                    idx_next      = idx_inc[CW-1:0];
                    mem_req.raddr = idx_inc[IW-1:0];
                end
            end

            ovl_pkg::ST_SHIFT: begin
                // Move the entry one place toward the head
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg[IW-1:0];
                mem_req.wdata = rd_data;
                if (idx_two < count_ext) begin
                    idx_next      = idx_inc[CW-1:0];
                    mem_req.raddr = idx_two[IW-1:0];
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = ovl_pkg::ST_FIN;
                end
            end

            ovl_pkg::ST_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_pos_next   = ovl_pkg::to_out(pos_reg);
                    m_cnt_next   = ovl_pkg::to_out(count_reg);
                    m_ovf_next   = ovf_reg;
                    state_next   = ovl_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ovl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ovl_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        ovf_reg     <= ovf_next;
        m_found_reg <= m_found_next;
        m_pos_reg   <= m_pos_next;
        m_cnt_reg   <= m_cnt_next;
        m_ovf_reg   <= m_ovf_next;
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;

    // Cycles without any accepted beat on either channel before giving up.
    localparam int STALL_LIMIT = 4000;
    // Cycles to wait once the result queue has drained.
    localparam int TAIL_CYCLES = 40;
    // Random beats per idling phase (four phases).
    localparam int BEATS_PER_PHASE = 129;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       found;
        logic [4:0] position;
        logic [4:0] entry_count;
        logic       overflow;
    } list_result_t;

    // One row of the directed table. A row may repeat, bumping the value by one each time.
    // Where 'typed' is set the result is written out by hand, otherwise the list model decides.
    typedef struct {
        ovl_pkg::kind_t kind;
        logic [31:0]    value;
        int             reps;
        bit             typed;
        list_result_t   res;
    } dir_row_t;

    localparam list_result_t NO_RES = '0;
    localparam int N_ROWS = 19;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic               m_found;
    logic [4:0]         m_position;
    logic [4:0]         m_entry_count;
    logic               m_overflow;

    // Hand-typed expectation travelling with the beat currently on the input channel.
    bit           beat_typed;
    list_result_t beat_res;

    // List model: contents from head, and number held.
    logic [31:0]  model_vals [ovl_pkg::CAPACITY];
    int           model_len;

    list_result_t pending_results[$];
    int           mismatches;
    int           quiet_cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic [31:0]  value_pool [8];
    dir_row_t     directed_rows [N_ROWS];

    ordered_value_list dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_position    (m_position),
        .m_entry_count (m_entry_count),
        .m_overflow    (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Apply one operation to the list model and return the result it gives.
    function automatic list_result_t list_apply(input ovl_pkg::kind_t kind,
                                                input logic [31:0] v);
        list_result_t r;
        int           hit;
        r   = '0;
        hit = -1;
        if (kind == ovl_pkg::KIND_SEARCH || kind == ovl_pkg::KIND_REMOVE) begin
            for (int i = 0; i < model_len; i++) begin
                if (hit < 0 && model_vals[i] == v)
                    hit = i;
            end
        end
        case (kind)
            ovl_pkg::KIND_APPEND: begin
                if (model_len >= ovl_pkg::CAPACITY) begin
                    r.overflow = 1'b1;
                end else begin
                    model_vals[model_len] = v;
                    r.position = 5'(model_len);
                    model_len++;
                end
            end
            ovl_pkg::KIND_SEARCH: begin
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = 5'(hit);
                end
            end
            ovl_pkg::KIND_REMOVE: begin
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = 5'(hit);
                    // close the gap, keeping order
                    for (int i = hit; i + 1 < model_len; i++)
                        model_vals[i] = model_vals[i + 1];
                    model_len--;
                end
            end
            default: begin
                model_len = 0;
            end
        endcase
        r.entry_count = 5'(model_len);
        return r;
    endfunction

    // Present one beat on the input channel and hold it until accepted.
    // Enter and leave at a falling edge; valid is only lowered for an idle gap.
    task automatic send_beat(input ovl_pkg::kind_t kind, input logic [31:0] v,
                             input bit typed, input list_result_t res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_kind     = kind;
        s_value    = v;
        beat_typed = typed;
        beat_res   = res;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain_results;
        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    // Refill the value pool: extremes plus a few random patterns, so that searches and
    // removes hit often and duplicates turn up.
    task automatic refresh_pool;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;
    endtask

    // Receiver: stall at random, changing ready only on the falling edge.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: sample both channels at the rising edge. Predict first, then check, so a
    // result leaving on the same edge as a new beat arrives still meets its own expectation.
    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (!aresetn) begin
            model_len    = 0;
            quiet_cycles = 0;
        end else begin
            if (s_valid && s_ready) begin
                want = list_apply(ovl_pkg::kind_t'(s_kind), s_value);
                if (beat_typed)
                    want = beat_res;
                pending_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = '{m_found, m_position, m_entry_count, m_overflow};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: stray result f=%0d p=%0d c=%0d o=%0d",
                                 $time, got.found, got.position, got.entry_count,
                                 got.overflow);
                end else begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found || got.position !== want.position ||
                        got.entry_count !== want.entry_count ||
                        got.overflow !== want.overflow) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: exp f/p/c/o %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     $time, want.found, want.position, want.entry_count,
                                     want.overflow, got.found, got.position,
                                     got.entry_count, got.overflow);
                    end
                end
            end
            // Watchdog: advance while neither channel moves a beat.
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        ovl_pkg::kind_t kind;
        logic [31:0]    v;
        int             sel;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = ovl_pkg::KIND_APPEND;
        s_value        = '0;
        beat_typed     = 1'b0;
        beat_res       = NO_RES;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;

        // Directed part: empty list, extremes, duplicates, head and tail removal,
        // a full list with a dropped append, and clear.
        directed_rows = '{
            '{ovl_pkg::KIND_SEARCH, 32'h0000_0000, 1,  1'b1, '{1'b0, 5'd0, 5'd0,  1'b0}},
            '{ovl_pkg::KIND_REMOVE, 32'h7FFF_FFFF, 1,  1'b1, '{1'b0, 5'd0, 5'd0,  1'b0}},
            '{ovl_pkg::KIND_APPEND, 32'h8000_0000, 1,  1'b1, '{1'b0, 5'd0, 5'd1,  1'b0}},
            '{ovl_pkg::KIND_APPEND, 32'h7FFF_FFFF, 1,  1'b1, '{1'b0, 5'd1, 5'd2,  1'b0}},
            '{ovl_pkg::KIND_APPEND, 32'h0000_0000, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_APPEND, 32'hFFFF_FFFF, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_APPEND, 32'h7FFF_FFFF, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_SEARCH, 32'h7FFF_FFFF, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_SEARCH, 32'h1234_5678, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_REMOVE, 32'h7FFF_FFFF, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_REMOVE, 32'h8000_0000, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_REMOVE, 32'h7FFF_FFFF, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_CLEAR,  32'h5A5A_5A5A, 1,  1'b1, '{1'b0, 5'd0, 5'd0,  1'b0}},
            '{ovl_pkg::KIND_APPEND, 32'h5555_5550, 16, 1'b0, NO_RES},
            '{ovl_pkg::KIND_APPEND, 32'hAAAA_AAAA, 1,  1'b1, '{1'b0, 5'd0, 5'd16, 1'b1}},
            '{ovl_pkg::KIND_SEARCH, 32'h5555_555F, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_REMOVE, 32'h5555_5550, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_APPEND, 32'hAAAA_AAAA, 1,  1'b0, NO_RES},
            '{ovl_pkg::KIND_CLEAR,  32'h0000_0000, 1,  1'b1, '{1'b0, 5'd0, 5'd0,  1'b0}}
        };

        // Hold reset, then release it on a falling edge.
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            for (int r = 0; r < directed_rows[i].reps; r++)
                send_beat(directed_rows[i].kind, directed_rows[i].value + r,
                          directed_rows[i].typed, directed_rows[i].res);
        end
        drain_results();

        // Random part, one idling phase at a time; drain between phases so the sender
        // also sits idle while the block works off everything outstanding.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            refresh_pool();
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // Lean towards append so the list fills up and overflows now and then;
                // clear is rare so long lists survive.
                sel = $urandom_range(99);
                if (sel < 45)
                    kind = ovl_pkg::KIND_APPEND;
                else if (sel < 70)
                    kind = ovl_pkg::KIND_SEARCH;
                else if (sel < 95)
                    kind = ovl_pkg::KIND_REMOVE;
                else
                    kind = ovl_pkg::KIND_CLEAR;
                if ($urandom_range(99) < 80)
                    v = value_pool[$urandom_range(7)];
                else
                    v = $urandom;
                send_beat(kind, v, 1'b0, NO_RES);
            end
            drain_results();
        end

        // Let the block settle, then judge the run.
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
